/* hw/rtl/raster_row_rle_cell_decoder_macros.svh */
// Assertion macros for the checker file of the decoder.
`ifndef RASTER_ROW_RLE_CELL_DECODER_MACROS_SVH
`define RASTER_ROW_RLE_CELL_DECODER_MACROS_SVH

// Checked at every rising edge outside reset.
`define RRCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RRCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rrcd_pkg.sv */
package rrcd_pkg;

  localparam logic [1:0] REG_FORMAT_MODE   = 2'd0;
  localparam logic [1:0] REG_DEFAULT_BYTES = 2'd1;
  localparam logic [1:0] REG_COLUMNS       = 2'd2;

  localparam logic [1:0] FMT_UNCOMPRESSED = 2'd0;
  localparam logic [1:0] FMT_OLD_RLE      = 2'd1;
  localparam logic [1:0] FMT_NEW_HEADER   = 2'd2;

  localparam logic [7:0] SIGN_BIT = 8'o200;
  localparam logic [7:0] MAG_MASK = 8'o177;
  localparam int unsigned BYTE_BITS = 8;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        row_start;
    logic [17:0] row_length;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic [7:0]         repeat_count;
    logic               end_of_row;
    logic               bad_width;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  format_mode;
    logic [2:0]  default_value_bytes;
    logic [15:0] columns;
  } cfg_t;

  typedef struct packed {
    logic        run_mode;
    logic [2:0]  value_bytes;
    logic [2:0]  byte_index;
    logic [31:0] value_accumulator;
    logic        negative_flag;
    logic [7:0]  run_repeat;
    logic [17:0] bytes_left;
  } state_t;

  typedef struct packed {
    logic      emit;
    out_beat_t beat;
  } step_t;

endpackage

/* hw/rtl/raster_row_rle_cell_decoder.sv */
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    in_data (one stored row byte)
// out      out        out_valid / out_ready  out_data (value, count, flags)
// One byte is taken per cycle unless the output stalls; its result is registered in out_data.
// The decode of a byte is a single pass of logic from the state registers to the result register.
// A held result stalls input only while out_ready is low; otherwise it is replaced in the same cycle.
// Synchronous reset clears the row state and the result register's valid flag.
// Configuration writes are always taken and apply to the next byte.
module raster_row_rle_cell_decoder
  import rrcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  step_t  step;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  rrcd_step u_step (
    .cfg  (cfg),
    .st   (st),
    .beat (in_data),
    .nxt  (st_next),
    .res  (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format_mode         <= FMT_UNCOMPRESSED;
      cfg.default_value_bytes <= 3'd1;
      cfg.columns             <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT_MODE:   cfg.format_mode         <= cfg_data[1:0];
        REG_DEFAULT_BYTES: cfg.default_value_bytes <= cfg_data[2:0];
        REG_COLUMNS:       cfg.columns             <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.run_mode          <= 1'b0;
      st.value_bytes       <= 3'd1;
      st.byte_index        <= '0;
      st.value_accumulator <= '0;
      st.negative_flag     <= 1'b0;
      st.run_repeat        <= '0;
      st.bytes_left        <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && step.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.emit) begin
      out_data <= step.beat;
    end
  end

endmodule

/* hw/rtl/rrcd_step.sv */
module rrcd_step
  import rrcd_pkg::*;
(
  input  cfg_t     cfg,
  input  state_t   st,
  input  in_beat_t beat,
  output state_t   nxt,
  output step_t    res
);

  function automatic logic [2:0] clamp_width(input logic [2:0] w);
    logic [2:0] r;
    r = w;
    if (w == 3'd0) begin
      r = 3'd1;
    end else if (w > 3'd4) begin
      r = 3'd4;
    end
    return r;
  endfunction

  logic        go;
  logic        header_bad;
  logic [18:0] cell_bytes;
  logic [2:0]  index_inc;
  logic [3:0]  tuple_len;
  logic [7:0]  b;

  assign b          = beat.data_byte;
  assign header_bad = (b == 8'd0) || (b > 8'd4);
  assign cell_bytes = 19'(b[2:0]) * 19'(cfg.columns);

  always_comb begin
    nxt       = st;
    res       = '0;
    go        = 1'b1;
    index_inc = '0;
    tuple_len = '0;
    if (beat.row_start) begin
      nxt.bytes_left        = beat.row_length;
      nxt.byte_index        = '0;
      nxt.value_accumulator = '0;
      nxt.negative_flag     = 1'b0;
      nxt.run_repeat        = '0;
      if (beat.row_length == '0) begin
        nxt.run_mode    = 1'b0;
        nxt.value_bytes = clamp_width(cfg.default_value_bytes);
        go              = 1'b0;
      end else if (cfg.format_mode == FMT_NEW_HEADER) begin
        go = 1'b0;
        if (header_bad) begin
          nxt.value_bytes = '0;
          nxt.run_mode    = 1'b0;
        end else begin
          nxt.value_bytes = b[2:0];
          nxt.run_mode    = {1'b0, beat.row_length - 18'd1} < cell_bytes;
        end
        nxt.bytes_left = beat.row_length - 18'd1;
        if (header_bad && nxt.bytes_left == '0) begin
          res.emit            = 1'b1;
          res.beat.end_of_row = 1'b1;
          res.beat.bad_width  = 1'b1;
        end
      end else begin
        nxt.value_bytes = clamp_width(cfg.default_value_bytes);
        nxt.run_mode    = (cfg.format_mode == FMT_OLD_RLE);
      end
    end else if (st.bytes_left == '0) begin
      go = 1'b0;
    end

    if (go) begin
      nxt.bytes_left = nxt.bytes_left - 18'd1;
      if (nxt.value_bytes == '0) begin
        if (nxt.bytes_left == '0) begin
          res.emit            = 1'b1;
          res.beat.end_of_row = 1'b1;
          res.beat.bad_width  = 1'b1;
        end
      end else begin
        if (nxt.run_mode && nxt.byte_index == '0) begin
          nxt.run_repeat = b;
        end else if (nxt.byte_index == {2'b0, nxt.run_mode}) begin
          if (nxt.value_bytes == 3'd4 && (b & SIGN_BIT) != '0) begin
            nxt.negative_flag     = 1'b1;
            nxt.value_accumulator = {24'd0, b & MAG_MASK};
          end else begin
            nxt.negative_flag     = 1'b0;
            nxt.value_accumulator = {24'd0, b};
          end
        end else begin
          nxt.value_accumulator = {nxt.value_accumulator[31-BYTE_BITS:0], b};
        end
        index_inc      = nxt.byte_index + 3'd1;
        nxt.byte_index = index_inc;
        tuple_len      = {1'b0, nxt.value_bytes} + {3'b0, nxt.run_mode};
        if ({1'b0, index_inc} >= tuple_len) begin
          res.emit              = 1'b1;
          res.beat.cell_value   = nxt.negative_flag ? -$signed(nxt.value_accumulator)
                                                    : $signed(nxt.value_accumulator);
          res.beat.repeat_count = nxt.run_mode ? nxt.run_repeat : 8'd1;
          res.beat.end_of_row   = (nxt.bytes_left == '0);
          res.beat.bad_width    = 1'b0;
          nxt.byte_index        = '0;
        end
      end
    end
  end

endmodule

/* hw/rtl/rrcd_checker.sv */
`include "raster_row_rle_cell_decoder_macros.svh"

module rrcd_checker
  import rrcd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  logic bad_beat_clean;

  assign bad_beat_clean = out_data.end_of_row && (out_data.cell_value == 32'sd0) &&
                          (out_data.repeat_count == 8'd0);

  `RRCD_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "result left after reset")

  `RRCD_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `RRCD_ASSERT(a_bad_row_result, out_valid && out_data.bad_width |-> bad_beat_clean, "bad beat")

  `RRCD_ASSERT(a_input_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled needlessly")

endmodule

bind raster_row_rle_cell_decoder rrcd_checker u_rrcd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
